/* rtl/core/letp_pkg.sv */
// Shared types and constants for the linear equation term parser.
// No dependencies. Used by the top level, the digit accumulator and the checker.
package letp_pkg;

   // Default width of the coefficient and denominator accumulators.
   localparam int COEF_BITS_DEFAULT = 31;

   // Largest magnitude that a result field can carry.
   localparam logic [30:0] OUT_MAX = 31'h7FFF_FFFF;

   // Request side layout.
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 2;

   // Response side layout: tdata fields from the lowest bit up.
   localparam int VAR_LSB     = 0;
   localparam int NUM_LSB     = 5;
   localparam int DEN_LSB     = 37;
   localparam int EQ_BIT      = 68;
   localparam int LO_LSB      = 69;
   localparam int COLS_LSB    = 74;
   localparam int RSP_TDATA_W = 80;

   // Number of variable letters.
   localparam logic [5:0] VAR_COUNT     = 6'd26;
   localparam logic [4:0] MAX_VAR_INDEX = 5'd25;

   typedef enum logic [1:0] {
      CMD_CHAR = 2'd0,
      CMD_EOL  = 2'd1,
      CMD_NEW  = 2'd2
   } command_type;

   localparam logic KIND_TERM = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   localparam logic [7:0] CHAR_A     = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_Z     = 8'h7A;  // 'z'
   localparam logic [7:0] CHAR_0     = 8'h30;  // '0'
   localparam logic [7:0] CHAR_9     = 8'h39;  // '9'
   localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
   localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;  // '='

   typedef struct packed {
      logic [4:0]         column_count;
      logic [4:0]         lowest_var;
      logic               has_equality;
      logic [30:0]        denominator;
      logic signed [31:0] numerator;
      logic [4:0]         var_index;
      logic               kind;
   } rsp_payload_type;

endpackage

/* rtl/core/linear_equation_term_parser.sv */
// Top level of the linear equation term parser: parse state, result register, handshake.
// Depends on letp_pkg and letp_digit_acc.
//
// The parser takes one request per clock cycle when not stalled and gives at most one
// response per request, in the cycle after acceptance. A request carries a command in
// req_tuser (character, end of line, start of a new system) and an ASCII character in
// req_tdata. Digits build a saturating decimal coefficient, or a denominator after '/';
// '-' and '+' set the sign; a lowercase letter emits a term with its variable index and
// an exact signed fraction (a missing or zero coefficient counts as one, a missing or
// zero denominator as one); end of line emits the constant after '=' together with the
// lowest variable index and the column span seen since the start of the system. All the
// work of a request is done in the cycle it is accepted, so the sustained rate is one
// request per cycle. The only thing that stalls the request side is a response held in
// the single output register while rsp_tready is low: req_tready is high whenever that
// register is empty or is being emptied in the same cycle.
module linear_equation_term_parser #(
   parameter int COEF_BITS = letp_pkg::COEF_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [letp_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [7:0] char_code
   input  logic [letp_pkg::REQ_TUSER_W-1:0]   req_tuser,  // [1:0] command
   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [4:0] var_index, [36:5] numerator, [67:37] denominator, [68] has_equality,
   // [73:69] lowest_var, [78:74] column_count, [79] zero
   output logic [letp_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tuser   // [0] kind
);
   import letp_pkg::*;

   // Width used to compare an accumulator against the 31-bit output limit.
   localparam int MAGW = (COEF_BITS > 31) ? COEF_BITS : 31;

   // Line state.
   logic [COEF_BITS-1:0] coef_ff, coef_in;
   logic                 neg_ff, neg_in;
   logic                 slash_ff, slash_in;
   logic [COEF_BITS-1:0] denom_ff, denom_in;
   logic                 eq_ff, eq_in;
   // System state: range of variables seen.
   logic                 any_var_ff, any_var_in;
   logic [4:0]           min_var_ff, min_var_in;
   logic [4:0]           max_var_ff, max_var_in;
   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 result_fire;
   command_type          cmd;
   logic [7:0]           ch;
   logic [7:0]           letter_off;
   logic [4:0]           idx;
   logic [COEF_BITS-1:0] acc_sel;
   logic [COEF_BITS-1:0] acc_next;
   logic [COEF_BITS-1:0] term_mag;
   logic                 den_given;

   function automatic logic [30:0] clamp_out(input logic [COEF_BITS-1:0] v);
      logic [MAGW-1:0] e;
      e = MAGW'(v);
      if (e > MAGW'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return e[30:0];
   endfunction

   function automatic logic signed [31:0] apply_sign(input logic [30:0] m, input logic neg);
      logic signed [31:0] s;
      s = $signed({1'b0, m});
      return neg ? -s : s;
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign cmd        = command_type'(req_tuser);
   assign ch         = req_tdata;
   assign letter_off = ch - CHAR_A;
   assign idx        = letter_off[4:0];

   // One shared digit unit: the slash flag decides which accumulator it extends.
   assign acc_sel = slash_ff ? denom_ff : coef_ff;

   letp_digit_acc #(
      .COEF_BITS (COEF_BITS)
   ) u_digit_acc (
      .acc      (acc_sel),
      .digit    (4'(ch - CHAR_0)),
      .acc_next (acc_next)
   );

   assign term_mag  = (coef_ff == '0) ? COEF_BITS'(1) : coef_ff;
   // A denominator counts only when a slash was seen and a nonzero value was built.
   assign den_given = slash_ff && (denom_ff != '0);

   always_comb begin
      coef_in     = coef_ff;
      neg_in      = neg_ff;
      slash_in    = slash_ff;
      denom_in    = denom_ff;
      eq_in       = eq_ff;
      any_var_in  = any_var_ff;
      min_var_in  = min_var_ff;
      max_var_in  = max_var_ff;
      result_fire = 1'b0;
      rsp_data_in = '0;
      rsp_data_in.denominator = 31'd1;

      if (accept) begin
         case (cmd)
            CMD_NEW: begin
               coef_in    = '0;
               neg_in     = 1'b0;
               slash_in   = 1'b0;
               denom_in   = '0;
               eq_in      = 1'b0;
               any_var_in = 1'b0;
               min_var_in = '0;
               max_var_in = '0;
            end
            CMD_EOL: begin
               result_fire = 1'b1;
               rsp_data_in.kind         = KIND_EOL;
               rsp_data_in.has_equality = eq_ff;
               if (eq_ff) begin
                  rsp_data_in.numerator = apply_sign(clamp_out(coef_ff), neg_ff);
                  if (den_given) begin
                     rsp_data_in.denominator = clamp_out(denom_ff);
                  end
               end
               if (any_var_ff) begin
                  rsp_data_in.lowest_var   = min_var_ff;
                  rsp_data_in.column_count = (max_var_ff - min_var_ff) + 5'd1;
               end
               coef_in  = '0;
               neg_in   = 1'b0;
               slash_in = 1'b0;
               denom_in = '0;
               eq_in    = 1'b0;
            end
            CMD_CHAR: begin
               if (ch == CHAR_SLASH) begin
                  slash_in = 1'b1;
               end else if (ch >= CHAR_0 && ch <= CHAR_9) begin
                  if (slash_ff) begin
                     denom_in = acc_next;
                  end else begin
                     coef_in = acc_next;
                  end
               end else if (ch == CHAR_MINUS) begin
                  neg_in = 1'b1;
               end else if (ch == CHAR_PLUS) begin
                  neg_in = 1'b0;
               end else if (ch >= CHAR_A && ch <= CHAR_Z) begin
                  result_fire = 1'b1;
                  rsp_data_in.kind      = KIND_TERM;
                  rsp_data_in.var_index = idx;
                  rsp_data_in.numerator = apply_sign(clamp_out(term_mag), neg_ff);
                  if (den_given) begin
                     // A completed fraction closes the denominator; a bare or zero
                     // denominator leaves the slash open for later digits.
                     rsp_data_in.denominator = clamp_out(denom_ff);
                     slash_in = 1'b0;
                     denom_in = '0;
                  end
                  coef_in = '0;
                  neg_in  = 1'b0;
                  if (!any_var_ff) begin
                     any_var_in = 1'b1;
                     min_var_in = idx;
                     max_var_in = idx;
                  end else begin
                     if (idx < min_var_ff) begin
                        min_var_in = idx;
                     end
                     if (idx > max_var_ff) begin
                        max_var_in = idx;
                     end
                  end
               end else if (ch == CHAR_EQUAL) begin
                  eq_in   = 1'b1;
                  coef_in = '0;
                  neg_in  = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      // An accept only happens when the output register is empty or draining.
      if (accept) begin
         rsp_valid_in = result_fire;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= '0;
         neg_ff       <= 1'b0;
         slash_ff     <= 1'b0;
         denom_ff     <= '0;
         eq_ff        <= 1'b0;
         any_var_ff   <= 1'b0;
         min_var_ff   <= '0;
         max_var_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         neg_ff       <= neg_in;
         slash_ff     <= slash_in;
         denom_ff     <= denom_in;
         eq_ff        <= eq_in;
         any_var_ff   <= any_var_in;
         min_var_ff   <= min_var_in;
         max_var_ff   <= max_var_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload needs no reset; it loads only with a new response.
   always_ff @(posedge clock) begin
      if (accept && result_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.kind;
   assign rsp_tdata  = {1'b0,
                        rsp_data_ff.column_count,
                        rsp_data_ff.lowest_var,
                        rsp_data_ff.has_equality,
                        rsp_data_ff.denominator,
                        rsp_data_ff.numerator,
                        rsp_data_ff.var_index};

endmodule

/* rtl/core/letp_digit_acc.sv */
// Saturating decimal digit accumulator: next = min(acc * 10 + digit, 2^COEF_BITS - 1).
// Depends on letp_pkg for the default width.
module letp_digit_acc #(
   parameter int COEF_BITS = letp_pkg::COEF_BITS_DEFAULT
) (
   input  logic [COEF_BITS-1:0] acc,
   input  logic [3:0]           digit,
   output logic [COEF_BITS-1:0] acc_next
);
   import letp_pkg::*;

   logic [COEF_BITS+3:0] wide;

   // Times ten as two shifted copies; the sum stays below 2^(COEF_BITS+4).
   always_comb begin
      wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (COEF_BITS+4)'(digit);
      if (wide[COEF_BITS+3:COEF_BITS] != 4'd0) begin
         acc_next = '1;
      end else begin
         acc_next = wide[COEF_BITS-1:0];
      end
   end

endmodule

/* rtl/core/letp_checker.sv */
// Port-level checker for the linear equation term parser, bound to the top level.
// Depends on letp_pkg and linear_equation_term_parser.
module letp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [letp_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [letp_pkg::REQ_TUSER_W-1:0] req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [letp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);
   import letp_pkg::*;

   logic [4:0]  chk_var;
   logic [31:0] chk_num;
   logic [30:0] chk_den;
   logic        chk_eq;
   logic [4:0]  chk_lo;
   logic [4:0]  chk_cols;

   assign chk_var  = rsp_tdata[VAR_LSB +: 5];
   assign chk_num  = rsp_tdata[NUM_LSB +: 32];
   assign chk_den  = rsp_tdata[DEN_LSB +: 31];
   assign chk_eq   = rsp_tdata[EQ_BIT];
   assign chk_lo   = rsp_tdata[LO_LSB +: 5];
   assign chk_cols = rsp_tdata[COLS_LSB +: 5];

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Response valid only rises in the cycle after an accepted request.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("response without a request");

   // Terms carry a nonzero coefficient, a valid letter and no line fields.
   a_term_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_TERM |->
         chk_num != 32'd0 && chk_var <= MAX_VAR_INDEX && !chk_eq &&
         chk_lo == 5'd0 && chk_cols == 5'd0 && chk_den != 31'd0)
      else $error("malformed term response");

   // End-of-line responses keep the variable span inside the alphabet.
   a_eol_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_EOL |->
         chk_var == 5'd0 && chk_den != 31'd0 &&
         ({1'b0, chk_lo} + {1'b0, chk_cols}) <= VAR_COUNT &&
         (chk_eq || chk_num == 32'd0) && (chk_cols != 5'd0 || chk_lo == 5'd0))
      else $error("malformed end-of-line response");

endmodule

bind linear_equation_term_parser letp_checker u_letp_checker (.*);
